>>> rtl/core/acked_record_queue_with_expiry_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the acked record queue
// Shared concurrent assertion forms, clocked on clk, reset on rst.
// ----------------------------------------------------------------------------
`ifndef ACKED_RECORD_QUEUE_WITH_EXPIRY_TOP_DEFINES_SVH
`define ACKED_RECORD_QUEUE_WITH_EXPIRY_TOP_DEFINES_SVH

// checked outside reset
`define ARQE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define ARQE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/arqe_pkg.sv
// ----------------------------------------------------------------------------
// arqe_pkg
// Types and codes of the acked record queue.
// ----------------------------------------------------------------------------
package arqe_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_NONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SLOT_EMPTY   = 3'd0,
    SLOT_QUEUED  = 3'd1,
    SLOT_FLIGHT  = 3'd2,
    SLOT_ACKED   = 3'd3,
    SLOT_DROPPED = 3'd4
  } slot_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FETCH,
    FSM_FETCH_OUT,
    FSM_WRITE
  } fsm_t;

  typedef enum logic [1:0] {
    PH_DUP,
    PH_EXP,
    PH_OLD,
    PH_ACK
  } phase_t;

  localparam int TIME_BITS = 48;
  localparam int SEQ_BITS  = 32;
  localparam int DROP_BITS = 32;
  localparam logic [TIME_BITS-1:0] TTL_RESET = 48'd300000000;

endpackage

>>> rtl/core/acked_record_queue_with_expiry_top.sv
// ----------------------------------------------------------------------------
// acked_record_queue_with_expiry_top
// Slot table of timestamped records with enqueue, dequeue, ack and expiry.
// ----------------------------------------------------------------------------
// Usage: drive kind, sequence_req, record_payload and now_time and raise
// start while busy is low; the item is taken at that edge. One result item
// follows, shown for exactly one cycle with done high; the receiver cannot
// stall it. live_records, in_flight and drops are valid in the done cycle.
// Record contents sit in a synchronous table memory; slot states are
// flops. Each pass walks the table one entry per cycle, paced by the
// memory read port. The passes per operation are:
//   tick, ack: one pass, then done
//   dequeue: an oldest pass, then a record fetch; no pass when refused
//   enqueue: a duplicate pass, plus an expiry pass and an oldest pass on a
//   full table, plus one write state
// Reset clears all slots to empty, counters to zero, time_to_live to
// 300000000. time_to_live is set over APB, paddr not decoded (64-bit data,
// low 48 bits used); unchecked: the user must write it only while idle.
// ----------------------------------------------------------------------------
module acked_record_queue_with_expiry_top
  import arqe_pkg::*;
#(
  parameter int SLOTS        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [SEQ_BITS-1:0]           sequence_req,
  input  logic [PAYLOAD_BITS-1:0]       record_payload,
  input  logic [TIME_BITS-1:0]          now_time,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [SEQ_BITS-1:0]           out_sequence,
  output logic [PAYLOAD_BITS-1:0]       out_payload,
  output logic [$clog2(SLOTS+1)-1:0]    live_records,
  output logic                          in_flight,
  output logic [DROP_BITS-1:0]          drops
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS+1);
  localparam int EW = TIME_BITS + SEQ_BITS + PAYLOAD_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS-1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
  localparam logic [DROP_BITS-1:0] DROP_MAX = '1;

  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] raddr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;

  fsm_t fsm, fsm_next;
  phase_t phase, phase_next;
  logic [CW-1:0] cnt, cnt_next;
  logic pv, pv_next;
  logic [IW-1:0] pidx, pidx_next;
  slot_state_t slot_st [SLOTS];
  slot_state_t slot_st_next [SLOTS];
  logic flight_flag, flight_flag_next;
  logic [IW-1:0] flight_slot, flight_slot_next;
  logic [CW-1:0] live_total, live_total_next;
  logic [DROP_BITS-1:0] drop_total, drop_total_next;
  logic [IW-1:0] tail_slot, tail_slot_next;
  logic [TIME_BITS-1:0] ttl;

  kind_t kind_q, kind_q_next;
  logic [SEQ_BITS-1:0] seq_q, seq_q_next;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_q_next;
  logic [TIME_BITS-1:0] now_q, now_q_next;
  logic hit, hit_next;
  logic best_valid, best_valid_next;
  logic [IW-1:0] best_idx, best_idx_next;
  logic [TIME_BITS-1:0] best_time, best_time_next;

  logic fin;
  status_t fin_status;
  logic [SEQ_BITS-1:0] fin_seq;
  logic [PAYLOAD_BITS-1:0] fin_pay;

  logic [TIME_BITS-1:0] r_time;
  logic [SEQ_BITS-1:0] r_seq;
  logic [PAYLOAD_BITS-1:0] r_pay;
  slot_state_t cur;
  logic last;
  logic [IW-1:0] wslot;
  logic free_found;

  assign r_time = rd_q[EW-1 -: TIME_BITS];
  assign r_seq  = rd_q[PAYLOAD_BITS +: SEQ_BITS];
  assign r_pay  = rd_q[PAYLOAD_BITS-1:0];

  assign pready = 1'b1;
  assign prdata = {16'd0, ttl};
  assign busy = (fsm != FSM_IDLE);
  assign live_records = live_total;
  assign in_flight = flight_flag;
  assign drops = drop_total;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= {now_q, seq_q, pay_q};
    end
    rd_q <= mem[raddr];
  end

  // write slot: tail unless live, else lowest non-live
  always_comb begin
    wslot = tail_slot;
    free_found = 1'b0;
    if (slot_st[tail_slot] == SLOT_QUEUED || slot_st[tail_slot] == SLOT_FLIGHT) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!free_found && slot_st[i] != SLOT_QUEUED && slot_st[i] != SLOT_FLIGHT) begin
          wslot = IW'(i);
          free_found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    fsm_next = fsm;
    phase_next = phase;
    cnt_next = cnt;
    pv_next = 1'b0;
    pidx_next = pidx;
    slot_st_next = slot_st;
    flight_flag_next = flight_flag;
    flight_slot_next = flight_slot;
    live_total_next = live_total;
    drop_total_next = drop_total;
    tail_slot_next = tail_slot;
    kind_q_next = kind_q;
    seq_q_next = seq_q;
    pay_q_next = pay_q;
    now_q_next = now_q;
    hit_next = hit;
    best_valid_next = best_valid;
    best_idx_next = best_idx;
    best_time_next = best_time;
    fin = 1'b0;
    fin_status = STAT_OK;
    fin_seq = '0;
    fin_pay = '0;
    raddr = cnt[IW-1:0];
    mem_we = 1'b0;
    mem_wa = wslot;
    cur = slot_st[pidx];
    last = pv && (pidx == LAST_IDX);

    unique case (fsm)
      FSM_IDLE: begin
        cnt_next = '0;
        if (start) begin
          kind_q_next = kind_t'(kind);
          seq_q_next = sequence_req;
          pay_q_next = record_payload;
          now_q_next = now_time;
          hit_next = 1'b0;
          best_valid_next = 1'b0;
          fsm_next = FSM_SCAN;
          unique case (kind_t'(kind))
            KIND_ENQ: phase_next = PH_DUP;
            KIND_DEQ: begin
              phase_next = PH_OLD;
              if (flight_flag || live_total == '0) begin
                fin = 1'b1;
                fin_status = STAT_NONE;
                fsm_next = FSM_IDLE;
              end
            end
            KIND_ACK: phase_next = PH_ACK;
            KIND_TICK: phase_next = PH_EXP;
          endcase
        end
      end

      FSM_SCAN: begin
        if (cnt < SLOTS_C) begin
          pv_next = 1'b1;
          pidx_next = cnt[IW-1:0];
          cnt_next = cnt + 1'b1;
        end
        if (pv) begin
          unique case (phase)
            PH_DUP: begin
              if ((cur == SLOT_QUEUED || cur == SLOT_FLIGHT || cur == SLOT_ACKED)
                  && r_seq == seq_q) begin
                hit_next = 1'b1;
              end
            end
            PH_EXP: begin
              if (cur == SLOT_QUEUED && (now_q - r_time) >= ttl) begin
                slot_st_next[pidx] = SLOT_DROPPED;
                live_total_next = live_total_next - 1'b1;
                if (drop_total_next != DROP_MAX) begin
                  drop_total_next = drop_total_next + 1'b1;
                end
              end
            end
            PH_OLD: begin
              if (cur == SLOT_QUEUED && (!best_valid || r_time < best_time)) begin
                best_valid_next = 1'b1;
                best_idx_next = pidx;
                best_time_next = r_time;
              end
            end
            PH_ACK: begin
              if (!hit && (cur == SLOT_QUEUED || cur == SLOT_FLIGHT) && r_seq == seq_q) begin
                hit_next = 1'b1;
                slot_st_next[pidx] = SLOT_ACKED;
                live_total_next = live_total_next - 1'b1;
                if (flight_flag && flight_slot == pidx) begin
                  flight_flag_next = 1'b0;
                end
              end
            end
          endcase
        end
        if (last) begin
          cnt_next = '0;
          unique case (phase)
            PH_DUP: begin
              if (hit_next) begin
                fin = 1'b1;
                fin_status = STAT_DUP;
                fsm_next = FSM_IDLE;
              end else if (live_total_next >= SLOTS_C) begin
                phase_next = PH_EXP;
              end else begin
                fsm_next = FSM_WRITE;
              end
            end
            PH_EXP: begin
              if (kind_q == KIND_TICK) begin
                fin = 1'b1;
                fsm_next = FSM_IDLE;
              end else if (live_total_next >= SLOTS_C) begin
                phase_next = PH_OLD;
                best_valid_next = 1'b0;
              end else begin
                fsm_next = FSM_WRITE;
              end
            end
            PH_OLD: begin
              if (!best_valid_next) begin
                fin = 1'b1;
                fin_status = (kind_q == KIND_DEQ) ? STAT_NONE : STAT_FULL;
                fsm_next = FSM_IDLE;
              end else if (kind_q == KIND_DEQ) begin
                slot_st_next[best_idx_next] = SLOT_FLIGHT;
                flight_flag_next = 1'b1;
                flight_slot_next = best_idx_next;
                fsm_next = FSM_FETCH;
              end else begin
                slot_st_next[best_idx_next] = SLOT_DROPPED;
                live_total_next = live_total_next - 1'b1;
                if (drop_total_next != DROP_MAX) begin
                  drop_total_next = drop_total_next + 1'b1;
                end
                fsm_next = FSM_WRITE;
              end
            end
            PH_ACK: begin
              fin = 1'b1;
              fin_status = hit_next ? STAT_OK : STAT_NONE;
              fsm_next = FSM_IDLE;
            end
          endcase
        end
      end

      FSM_FETCH: begin
        raddr = best_idx;
        fsm_next = FSM_FETCH_OUT;
      end

      FSM_FETCH_OUT: begin
        fin = 1'b1;
        fin_seq = r_seq;
        fin_pay = r_pay;
        fsm_next = FSM_IDLE;
      end

      FSM_WRITE: begin
        mem_we = 1'b1;
        slot_st_next[wslot] = SLOT_QUEUED;
        live_total_next = live_total + 1'b1;
        tail_slot_next = (wslot == LAST_IDX) ? '0 : wslot + 1'b1;
        fin = 1'b1;
        fsm_next = FSM_IDLE;
      end

      default: fsm_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE;
      pv <= 1'b0;
      cnt <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st[i] <= SLOT_EMPTY;
      end
      flight_flag <= 1'b0;
      flight_slot <= '0;
      live_total <= '0;
      drop_total <= '0;
      tail_slot <= '0;
      ttl <= TTL_RESET;
      done <= 1'b0;
    end else begin
      fsm <= fsm_next;
      pv <= pv_next;
      cnt <= cnt_next;
      slot_st <= slot_st_next;
      flight_flag <= flight_flag_next;
      flight_slot <= flight_slot_next;
      live_total <= live_total_next;
      drop_total <= drop_total_next;
      tail_slot <= tail_slot_next;
      if (psel && penable && pwrite) begin
        ttl <= pwdata[TIME_BITS-1:0];
      end
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    pidx <= pidx_next;
    kind_q <= kind_q_next;
    seq_q <= seq_q_next;
    pay_q <= pay_q_next;
    now_q <= now_q_next;
    hit <= hit_next;
    best_valid <= best_valid_next;
    best_idx <= best_idx_next;
    best_time <= best_time_next;
    if (fin) begin
      status <= fin_status;
      out_sequence <= fin_seq;
      out_payload <= fin_pay;
    end
  end

endmodule

>>> rtl/core/arqe_checker.sv
// ----------------------------------------------------------------------------
// arqe_checker
// Port-level checks of the acked record queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "acked_record_queue_with_expiry_top_defines.svh"

module arqe_checker
  import arqe_pkg::*;
#(
  parameter int SLOTS        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       busy,
  input logic                       done,
  input logic [1:0]                 status,
  input logic [SEQ_BITS-1:0]        out_sequence,
  input logic [PAYLOAD_BITS-1:0]    out_payload,
  input logic [$clog2(SLOTS+1)-1:0] live_records,
  input logic                       in_flight
);

  localparam logic [$clog2(SLOTS+1)-1:0] SLOTS_C = ($clog2(SLOTS+1))'(SLOTS);

  `ARQE_ASSERT(a_done_idle, done |-> !busy, "result while busy")
  `ARQE_ASSERT(a_live_bound, done |-> live_records <= SLOTS_C, "live count over table size")
  `ARQE_ASSERT(a_flight_live, in_flight |-> live_records != '0, "in flight with no live record")
  `ARQE_ASSERT(a_out_zero, done && status != STAT_OK |-> out_sequence == '0 && out_payload == '0,
               "record output on failed item")
  `ARQE_ASSERT_RST(a_reset_idle, rst |=> !busy && !done, "not idle after reset")

endmodule

bind acked_record_queue_with_expiry_top arqe_checker #(
  .SLOTS(SLOTS),
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_arqe_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Record queue testbench
// Drives enqueue, dequeue, ack and tick items through the start/busy port and
// checks every done item against an in-bench model of the slot table. A short
// directed table comes first, then random traffic under four time_to_live
// settings written over APB, with sender gaps at varied rates.
// ----------------------------------------------------------------------------
module tb;
  import arqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    status_t     st;
    logic [31:0] seq;
    logic [63:0] pay;
    logic [4:0]  live;
    logic        fl;
    logic [31:0] drp;
  } outcome_t;

  typedef struct {
    kind_t       k;
    logic [31:0] seq;
    logic [63:0] pay;
    logic [47:0] now;
    bit          typed;
    outcome_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = '0;
  logic [31:0] sequence_req = '0;
  logic [63:0] record_payload = '0;
  logic [47:0] now_time = '0;
  logic done;
  logic [1:0] status;
  logic [31:0] out_sequence;
  logic [63:0] out_payload;
  logic [4:0] live_records;
  logic in_flight;
  logic [31:0] drops;

  acked_record_queue_with_expiry_top dut (.*);

  always #5 clk = ~clk;

  // slot table model
  slot_state_t m_state[NSLOT];
  logic [31:0] m_seq[NSLOT];
  logic [63:0] m_pay[NSLOT];
  logic [47:0] m_time[NSLOT];
  bit          m_fl;
  int          m_flslot, m_live, m_tail;
  logic [31:0] m_drops;
  logic [47:0] m_ttl;

  outcome_t pending_q[$];
  int mismatches = 0;
  int idle_pct = 0;
  int wdog = 0;
  logic [47:0] clock_us = '0;

  function automatic void bump_drops();
    if (m_drops != 32'hFFFF_FFFF) m_drops++;
  endfunction

  function automatic void expire_stale(logic [47:0] now);
    for (int i = 0; i < NSLOT; i++)
      if (m_state[i] == SLOT_QUEUED && (now - m_time[i]) >= m_ttl) begin
        m_state[i] = SLOT_DROPPED;
        bump_drops();
        m_live--;
      end
  endfunction

  function automatic int oldest_slot();
    int best;
    best = NSLOT;
    for (int i = 0; i < NSLOT; i++)
      if (m_state[i] == SLOT_QUEUED && (best == NSLOT || m_time[i] < m_time[best]))
        best = i;
    return best;
  endfunction

  function automatic bit slot_live(int i);
    return m_state[i] == SLOT_QUEUED || m_state[i] == SLOT_FLIGHT;
  endfunction

  function automatic status_t enqueue_record(logic [31:0] seq, logic [63:0] pay,
                                             logic [47:0] now);
    int w, o;
    for (int i = 0; i < NSLOT; i++)
      if ((slot_live(i) || m_state[i] == SLOT_ACKED) && m_seq[i] == seq)
        return STAT_DUP;
    if (m_live >= NSLOT) expire_stale(now);
    if (m_live >= NSLOT) begin
      o = oldest_slot();
      if (o == NSLOT) return STAT_FULL;
      m_state[o] = SLOT_DROPPED;
      bump_drops();
      m_live--;
    end
    w = m_tail;
    if (slot_live(w))
      for (int i = 0; i < NSLOT; i++)
        if (!slot_live(i)) begin
          w = i;
          break;
        end
    m_state[w] = SLOT_QUEUED;
    m_seq[w] = seq;
    m_pay[w] = pay;
    m_time[w] = now;
    m_live++;
    m_tail = (w + 1) % NSLOT;
    return STAT_OK;
  endfunction

  function automatic outcome_t queue_step(kind_t k, logic [31:0] seq, logic [63:0] pay,
                                          logic [47:0] now);
    outcome_t r;
    int o;
    r = '0;
    r.st = STAT_OK;
    case (k)
      KIND_ENQ: r.st = enqueue_record(seq, pay, now);
      KIND_DEQ: begin
        o = NSLOT;
        if (!m_fl && m_live != 0) o = oldest_slot();
        if (o == NSLOT) r.st = STAT_NONE;
        else begin
          m_state[o] = SLOT_FLIGHT;
          m_flslot = o;
          m_fl = 1'b1;
          r.seq = m_seq[o];
          r.pay = m_pay[o];
        end
      end
      KIND_ACK: begin
        r.st = STAT_NONE;
        for (int i = 0; i < NSLOT; i++)
          if (slot_live(i) && m_seq[i] == seq) begin
            m_state[i] = SLOT_ACKED;
            m_live--;
            if (m_fl && m_flslot == i) m_fl = 1'b0;
            r.st = STAT_OK;
            break;
          end
      end
      default: expire_stale(now);
    endcase
    r.live = m_live[4:0];
    r.fl = m_fl;
    r.drp = m_drops;
    return r;
  endfunction

  // drive one item, hold start until taken; leaves start high
  task automatic send_item(kind_t k, logic [31:0] seq, logic [63:0] pay, logic [47:0] now,
                           bit typed, outcome_t want);
    outcome_t got;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    kind <= k;
    sequence_req <= seq;
    record_payload <= pay;
    now_time <= now;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = queue_step(k, seq, pay, now);
    pending_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_ttl(logic [47:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd0;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    m_ttl = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic outcome_t oc(status_t st, int live, bit fl, int drp);
    outcome_t r;
    r = '0;
    r.st = st;
    r.live = 5'(live);
    r.fl = fl;
    r.drp = 32'(drp);
    return r;
  endfunction

  function automatic logic [31:0] pick_seq(bit fresh);
    int i;
    if (!fresh)
      for (int t = 0; t < 4; t++) begin
        i = $urandom_range(NSLOT - 1);
        if (m_state[i] != SLOT_EMPTY && m_state[i] != SLOT_DROPPED) return m_seq[i];
      end
    return $urandom;
  endfunction

  task automatic random_item();
    int sel;
    kind_t k;
    logic [31:0] seq;
    sel = $urandom_range(99);
    if ($urandom_range(99) < 3) clock_us = 48'({$urandom, $urandom});
    else clock_us = clock_us + $urandom_range(0, 300);
    if (sel < 42) begin
      k = KIND_ENQ;
      seq = pick_seq($urandom_range(9) != 0);
    end else if (sel < 62) begin
      k = KIND_DEQ;
      seq = $urandom;
    end else if (sel < 87) begin
      k = KIND_ACK;
      if (m_fl && $urandom_range(1)) seq = m_seq[m_flslot];
      else seq = pick_seq($urandom_range(4) == 0);
    end else begin
      k = KIND_TICK;
      seq = $urandom;
    end
    send_item(k, seq, {$urandom, $urandom}, clock_us, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    outcome_t e, a;
    if (!rst && done) begin
      a.st = status_t'(status);
      a.seq = out_sequence;
      a.pay = out_payload;
      a.live = live_records;
      a.fl = in_flight;
      a.drp = drops;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", a);
      end else begin
        e = pending_q.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, a);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    logic [47:0] ttl_set[4];
    int pct_set[4];
    for (int i = 0; i < NSLOT; i++) begin
      m_state[i] = SLOT_EMPTY;
      m_seq[i] = '0;
      m_pay[i] = '0;
      m_time[i] = '0;
    end
    m_fl = 0;
    m_flslot = 0;
    m_live = 0;
    m_tail = 0;
    m_drops = '0;
    m_ttl = TTL_RESET;

    rows = '{
      '{KIND_DEQ,  32'd0, 64'd0, 48'd0, 1, oc(STAT_NONE, 0, 0, 0)},
      '{KIND_ACK,  32'd7, 64'd0, 48'd0, 1, oc(STAT_NONE, 0, 0, 0)},
      '{KIND_TICK, 32'd0, 64'd0, 48'd0, 1, oc(STAT_OK, 0, 0, 0)},
      '{KIND_ENQ,  32'd0, 64'd0, 48'd0, 1, oc(STAT_OK, 1, 0, 0)},
      '{KIND_ENQ,  32'd0, '1, 48'd1, 1, oc(STAT_DUP, 1, 0, 0)},
      '{KIND_ENQ,  '1, '1, '1, 1, oc(STAT_OK, 2, 0, 0)},
      '{KIND_DEQ,  32'd0, 64'd0, '1, 0, '0},
      '{KIND_DEQ,  32'd0, 64'd0, '1, 1, oc(STAT_NONE, 2, 1, 0)},
      '{KIND_TICK, 32'd0, 64'd0, '1, 1, oc(STAT_OK, 2, 1, 0)},
      '{KIND_ACK,  32'd0, 64'd0, '1, 1, oc(STAT_OK, 1, 0, 0)},
      '{KIND_ENQ,  32'd0, 64'd5, '1, 1, oc(STAT_DUP, 1, 0, 0)},
      '{KIND_TICK, 32'd0, 64'd0, 48'd299999998, 1, oc(STAT_OK, 1, 0, 0)},
      '{KIND_TICK, 32'd0, 64'd0, 48'd299999999, 1, oc(STAT_OK, 0, 0, 1)},
      '{KIND_DEQ,  32'd0, 64'd0, 48'd300000000, 1, oc(STAT_NONE, 0, 0, 1)},
      '{KIND_ENQ,  32'd5, 64'hA5A5_5A5A_F00F_0FF0, 48'd300000000, 1, oc(STAT_OK, 1, 0, 1)},
      '{KIND_ENQ,  32'h8000_0000, '1, 48'd300000001, 0, '0},
      '{KIND_DEQ,  32'd0, 64'd0, 48'd300000002, 0, '0},
      '{KIND_ACK,  32'd5, 64'd0, 48'd300000003, 1, oc(STAT_OK, 1, 0, 1)},
      '{KIND_DEQ,  32'd0, 64'd0, 48'd300000004, 0, '0},
      '{KIND_ACK,  32'h8000_0000, 64'd0, 48'd300000005, 1, oc(STAT_OK, 0, 0, 1)}
    };
    ttl_set = '{48'd5000, 48'd1, 48'hFFFF_FFFF_FFFF, 48'd0};
    ttl_set[3] = 48'($urandom_range(200, 20000));
    pct_set = '{13, 47, 0, 0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].k, rows[i].seq, rows[i].pay, rows[i].now, rows[i].typed,
                rows[i].want);
    clock_us = 48'd300000010;

    for (int p = 0; p < 4; p++) begin
      drain();
      write_ttl(ttl_set[p]);
      idle_pct = pct_set[p];
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end
    drain();

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/arqe_pkg.sv
rtl/core/acked_record_queue_with_expiry_top.sv
rtl/core/arqe_checker.sv
bench/tb.sv
